@@ rtl/core/ubsd_pkg.sv @@
// Shared types and constants of the byte stream Unicode decoder.
// No dependencies; every other file of the block imports this package.
package ubsd_pkg;

  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_UTF8    = 2'd1;
  localparam logic [1:0] MODE_UTF16LE = 2'd2;
  localparam logic [1:0] MODE_UTF16BE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ILL   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]        cnt;
    logic [2:0][20:0]  cp;
    logic [2:0][1:0]   st;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

  typedef struct packed {
    logic [1:0]  need;
    logic [1:0]  st;
    logic [20:0] val;
  } lead_t;

endpackage

@@ rtl/core/ubsd_front.sv @@
// Front end: accepts bytes, keeps the UTF-8 and UTF-16 decode state and
// builds the bundle of up to three results per request. Depends on ubsd_pkg.
module ubsd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata,
  input  logic           in_push,
  input  logic [7:0]     in_data_byte,
  input  logic           in_end_of_stream,
  input  logic           q_full,
  output ubsd_pkg::q_wr_t q_wr
);
  import ubsd_pkg::*;

  logic [1:0]       mode_r;
  logic [2:0][7:0]  pend_r, pend_nxt;
  logic [1:0]       pcnt_r, pcnt_nxt;
  logic [1:0]       need_r, need_nxt;
  logic [20:0]      part_r, part_nxt;
  logic [7:0]       odd_r, odd_nxt;
  logic             oddv_r, oddv_nxt;
  logic [15:0]      hs_r, hs_nxt;
  logic             hsv_r, hsv_nxt;

  logic             accept;
  bundle_t          bnd;
  lead_t            l0, l1, l2;
  logic [20:0]      pv;
  logic [15:0]      u;

  function automatic lead_t classify(input logic [7:0] b);
    lead_t l;
    l.need = 2'd0;
    l.st   = ST_OK;
    l.val  = {13'd0, b};
    if (b[7:6] == 2'b10) begin
      l.st = ST_ILL;
    end else if (b[7:5] == 3'b110) begin
      l.need = 2'd1;
      l.val  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      l.need = 2'd2;
      l.val  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      l.need = 2'd3;
      l.val  = {18'd0, b[2:0]};
    end else if (b[7]) begin
      l.st = ST_ILL;
    end
    return l;
  endfunction

  function automatic bundle_t put(input bundle_t bi, input logic [20:0] cp,
                                  input logic [1:0] st);
    bundle_t bo;
    bo = bi;
    bo.cp[bi.cnt] = cp;
    bo.st[bi.cnt] = st;
    bo.cnt = bi.cnt + 2'd1;
    return bo;
  endfunction

  assign accept = in_push && !q_full;

  always_comb begin
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    need_nxt = need_r;
    part_nxt = part_r;
    odd_nxt  = odd_r;
    oddv_nxt = oddv_r;
    hs_nxt   = hs_r;
    hsv_nxt  = hsv_r;
    bnd      = '0;
    l0       = classify(in_data_byte);
    l1       = classify(pend_r[1]);
    l2       = classify(pend_r[2]);
    pv       = {part_r[14:0], in_data_byte[5:0]};
    u        = (mode_r == MODE_UTF16LE) ? {in_data_byte, odd_r} : {odd_r, in_data_byte};
    unique case (mode_r)
      MODE_RAW: begin
        if (!in_end_of_stream) begin
          bnd = put(bnd, {13'd0, in_data_byte}, ST_OK);
        end
      end
      MODE_UTF8: begin
        if (in_end_of_stream) begin
          if (pcnt_r != 2'd0) begin
            bnd = put(bnd, {13'd0, pend_r[0]}, ST_SHORT);
            if (pcnt_r >= 2'd2) begin
              if (l1.need == 2'd0) begin
                bnd = put(bnd, {13'd0, pend_r[1]}, l1.st);
              end else if (l1.need == 2'd1 && pcnt_r == 2'd3) begin
                bnd = put(bnd, {l1.val[14:0], pend_r[2][5:0]}, ST_OK);
              end else begin
                bnd = put(bnd, {13'd0, pend_r[1]}, ST_SHORT);
              end
              if (pcnt_r == 2'd3 && !(l1.need == 2'd1)) begin
                bnd = put(bnd, {13'd0, pend_r[2]},
                          (l2.need == 2'd0) ? l2.st : ST_SHORT);
              end
            end
          end
          pend_nxt = '0;
          pcnt_nxt = '0;
          need_nxt = '0;
          part_nxt = '0;
        end else if (need_r == 2'd0) begin
          if (l0.need == 2'd0) begin
            bnd = put(bnd, {13'd0, in_data_byte}, l0.st);
          end else begin
            part_nxt    = l0.val;
            need_nxt    = l0.need;
            pend_nxt[0] = in_data_byte;
            pcnt_nxt    = 2'd1;
          end
        end else begin
          need_nxt = need_r - 2'd1;
          if (need_r == 2'd1) begin
            bnd      = put(bnd, pv, ST_OK);
            part_nxt = '0;
            pcnt_nxt = '0;
            pend_nxt = '0;
          end else begin
            part_nxt = pv;
            pcnt_nxt = pcnt_r + 2'd1;
            case (pcnt_r)
              2'd1:    pend_nxt[1] = in_data_byte;
              2'd2:    pend_nxt[2] = in_data_byte;
              default: pend_nxt    = pend_r;
            endcase
          end
        end
      end
      default: begin
        if (in_end_of_stream) begin
          if (hsv_r) begin
            bnd = put(bnd, {5'd0, hs_r}, ST_SHORT);
          end
          odd_nxt  = '0;
          oddv_nxt = 1'b0;
          hs_nxt   = '0;
          hsv_nxt  = 1'b0;
        end else if (!oddv_r) begin
          odd_nxt  = in_data_byte;
          oddv_nxt = 1'b1;
        end else begin
          odd_nxt  = '0;
          oddv_nxt = 1'b0;
          if (hsv_r && u[15:10] == 6'b110111) begin
            bnd     = put(bnd, 21'h10000 + {1'b0, hs_r[9:0], u[9:0]}, ST_OK);
            hs_nxt  = '0;
            hsv_nxt = 1'b0;
          end else begin
            if (hsv_r) begin
              bnd = put(bnd, {5'd0, hs_r}, ST_ILL);
            end
            if (u[15:10] == 6'b110110) begin
              hs_nxt  = u;
              hsv_nxt = 1'b1;
            end else begin
              bnd     = put(bnd, {5'd0, u}, ST_OK);
              hs_nxt  = '0;
              hsv_nxt = 1'b0;
            end
          end
        end
      end
    endcase
  end

  assign q_wr.push = accept && (bnd.cnt != 2'd0);
  assign q_wr.data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF8;
      pend_r <= '0;
      pcnt_r <= '0;
      need_r <= '0;
      part_r <= '0;
      odd_r  <= '0;
      oddv_r <= 1'b0;
      hs_r   <= '0;
      hsv_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      pend_r <= '0;
      pcnt_r <= '0;
      need_r <= '0;
      part_r <= '0;
      odd_r  <= '0;
      oddv_r <= 1'b0;
      hs_r   <= '0;
      hsv_r  <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      need_r <= need_nxt;
      part_r <= part_nxt;
      odd_r  <= odd_nxt;
      oddv_r <= oddv_nxt;
      hs_r   <= hs_nxt;
      hsv_r  <= hsv_nxt;
    end
  end

endmodule

@@ rtl/core/ubsd_queue.sv @@
// Short queue of result bundles between the front and back ends.
// Depends on ubsd_pkg for the bundle type and depth.
module ubsd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  ubsd_pkg::q_wr_t q_wr,
  input  logic            q_pop,
  output logic            q_full,
  output ubsd_pkg::q_rd_t q_rd
);
  import ubsd_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push, do_pop;

  assign q_full   = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.data  = mem_r[rptr_r];
  assign do_push  = q_wr.push && !q_full;
  assign do_pop   = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ubsd_back.sv @@
// Back end: holds one bundle and hands out its results one per request.
// Depends on ubsd_pkg for the bundle type.
module ubsd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ubsd_pkg::q_rd_t q_rd,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [20:0]     out_codepoint,
  output logic [1:0]      out_status,
  output logic            out_last
);
  import ubsd_pkg::*;

  bundle_t     cur_r;
  logic        curv_r;
  logic [1:0]  idx_r;
  logic        fire;

  assign out_empty     = !curv_r;
  assign out_codepoint = cur_r.cp[idx_r];
  assign out_status    = cur_r.st[idx_r];
  assign out_last      = (idx_r == cur_r.cnt - 2'd1);
  assign fire          = out_pop && curv_r;
  assign q_pop         = q_rd.valid && (!curv_r || (fire && out_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curv_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      curv_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (out_last) begin
        curv_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/unicode_byte_stream_decoder.sv @@
// Byte stream Unicode decoder top level: front end, bundle queue, back end.
// Depends on ubsd_pkg, ubsd_front, ubsd_queue and ubsd_back.
// The decoder takes one byte request per cycle while not full and turns it into
// zero to three codepoint results in raw, UTF-8 or UTF-16 mode. The front end
// classifies each request and writes its results as one bundle into a four-entry
// queue; the back end delivers one result per cycle while out_pop is held, and a
// result passes through the queue and the back end's bundle register. Input stays
// at one request per cycle as long as requests average no more than one result
// each; full rises when the four bundles of the queue are taken. A configuration
// write selects the mode and clears any partial sequence, effective next cycle.
module unicode_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [20:0] out_codepoint,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import ubsd_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_pop;

  ubsd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (in_full),
    .q_wr             (q_wr)
  );

  ubsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_full (in_full),
    .q_rd   (q_rd)
  );

  ubsd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd          (q_rd),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_codepoint (out_codepoint),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == ST_OK || out_status == ST_ILL || out_status == ST_SHORT))
    else $error("result status out of range");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=> !out_empty)
    else $error("result of a request lost before its last one");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queue not cleared by reset");

endmodule
